// ===== src/mesh_vertex_lerp_normal_decode_unit_macros.svh =====
// Assertion helpers shared by the RTL of the vertex blend unit.
`ifndef MESH_VERTEX_LERP_NORMAL_DECODE_UNIT_MACROS_SVH
`define MESH_VERTEX_LERP_NORMAL_DECODE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MVLND_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mvlnd same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MVLND_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mvlnd next-cycle check failed");

`endif

// ===== src/mvlnd_pkg.sv =====
package mvlnd_pkg;

  localparam int PRE_STAGES = 7;
  localparam int SQ_STEPS   = 32;
  localparam int DIV_STEPS  = 15;
  localparam int NST        = PRE_STAGES + SQ_STEPS + DIV_STEPS;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [14:0] NORM_ONE   = 15'd16384;

  // Quarter wave of the sine table in Q1.14; the full 256-code wave is folded from it.
  localparam logic [15:0] QUARTER_WAVE [0:64] = '{
    16'd0,     16'd402,   16'd804,   16'd1205,  16'd1606,  16'd2006,  16'd2404,  16'd2801,
    16'd3196,  16'd3590,  16'd3981,  16'd4370,  16'd4756,  16'd5139,  16'd5520,  16'd5897,
    16'd6270,  16'd6639,  16'd7005,  16'd7366,  16'd7723,  16'd8076,  16'd8423,  16'd8765,
    16'd9102,  16'd9434,  16'd9760,  16'd10080, 16'd10394, 16'd10702, 16'd11003, 16'd11297,
    16'd11585, 16'd11866, 16'd12140, 16'd12406, 16'd12665, 16'd12916, 16'd13160, 16'd13395,
    16'd13623, 16'd13842, 16'd14053, 16'd14256, 16'd14449, 16'd14635, 16'd14811, 16'd14978,
    16'd15137, 16'd15286, 16'd15426, 16'd15557, 16'd15679, 16'd15791, 16'd15893, 16'd15986,
    16'd16069, 16'd16143, 16'd16207, 16'd16261, 16'd16305, 16'd16340, 16'd16364, 16'd16379,
    16'd16384
  };

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][15:0] nn;
    logic             wz;
    logic [2:0]       neg;
    logic [2:0][30:0] m;
  } carry_t;

  // Sine of an 8-bit angle code (a full turn is 256 codes), Q1.14.
  function automatic logic signed [15:0] sin_q14(input logic [7:0] k);
    logic [6:0]  idx;
    logic [15:0] mag;
    idx = k[6] ? 7'(7'd64 - {1'b0, k[5:0]}) : {1'b0, k[5:0]};
    mag = QUARTER_WAVE[idx];
    return k[7] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== src/mesh_vertex_lerp_normal_decode_unit.sv =====
// Pipeline: an input transfer loads the first of 54 pipeline stages, and the last one
// feeds the output register.
// Throughput: one vertex per cycle unless the pipe holds; 32 square-root stages and 15
// divider stages are fully pipelined. A skid register catches the one result that leaves the
// pipe while the output is stalled, and the whole pipe then holds until that result moves on.
// Reset (rst, synchronous, active high) clears the weight to zero and empties all stages.
`include "mesh_vertex_lerp_normal_decode_unit_macros.svh"

module mesh_vertex_lerp_normal_decode_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [16:0]  cfg_data,   // old_weight
  input  logic         s_tvalid,
  output logic         s_tready,
  // old_x, old_y, old_z, old_normal, new_x, new_y, new_z, new_normal
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
  output logic [143:0] m_tdata
);
  import mvlnd_pkg::*;

  logic [16:0] weight;
  logic [NST-1:0] v;
  logic en;

  // stage 1
  logic [16:0] s1_w;
  logic signed [2:0][15:0] s1_op, s1_np;
  logic signed [15:0] s1_ocl, s1_osl, s1_osn, s1_ocn;
  logic signed [15:0] s1_ncl, s1_nsl, s1_nsn, s1_ncn;
  // stage 2
  logic [16:0] s2_w;
  logic signed [33:0] s2_ppo [3];
  logic signed [33:0] s2_ppn [3];
  logic signed [31:0] s2_ox, s2_oy, s2_nx, s2_ny;
  logic signed [15:0] s2_oz, s2_nz;
  // stage 3
  logic [16:0] s3_w;
  logic [2:0][31:0] s3_pos;
  logic signed [15:0] s3_on [3];
  logic [2:0][15:0] s3_nn;
  // stage 4
  logic signed [33:0] s4_bo [3];
  logic signed [33:0] s4_bn [3];
  logic [2:0][31:0] s4_pos;
  logic [2:0][15:0] s4_nn;
  logic s4_wz;
  // stages 5 to 7
  carry_t s5_c, s6_c, s7_c;
  logic [61:0] s6_sq [3];
  logic [63:0] s7_sum;
  // square root and divider
  logic [63:0] sq_x [SQ_STEPS];
  logic [35:0] sq_rem [SQ_STEPS];
  logic [31:0] sq_root [SQ_STEPS];
  carry_t sq_c [SQ_STEPS];
  logic [63:0] sq_x_next [SQ_STEPS];
  logic [35:0] sq_rem_next [SQ_STEPS];
  logic [31:0] sq_root_next [SQ_STEPS];
  logic [47:0] dv_r [DIV_STEPS][3];
  logic [14:0] dv_q [DIV_STEPS][3];
  logic [31:0] dv_len [DIV_STEPS];
  carry_t dv_c [DIV_STEPS];
  logic [47:0] dv_r_next [DIV_STEPS][3];
  logic [14:0] dv_q_next [DIV_STEPS][3];
  // result, output and skid registers
  logic [143:0] res_data, out_data, sk_data;
  logic out_v, sk_v;

  function automatic logic signed [15:0] round_q14(input logic signed [31:0] p);
    logic signed [31:0] t;
    t = p + 32'sd8192;
    return t[29:14];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (cfg_valid && cfg_ready) begin
      weight <= (cfg_data > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data;
    end
  end

  // The whole pipe moves together unless a result is parked in the skid register.
  assign en       = !sk_v;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w   <= weight;
      s1_op  <= s_tdata[47:0];
      s1_np  <= s_tdata[111:64];
      s1_ocl <= sin_q14(8'(s_tdata[63:56] + 8'd64));
      s1_osl <= sin_q14(s_tdata[63:56]);
      s1_osn <= sin_q14(s_tdata[55:48]);
      s1_ocn <= sin_q14(8'(s_tdata[55:48] + 8'd64));
      s1_ncl <= sin_q14(8'(s_tdata[127:120] + 8'd64));
      s1_nsl <= sin_q14(s_tdata[127:120]);
      s1_nsn <= sin_q14(s_tdata[119:112]);
      s1_ncn <= sin_q14(8'(s_tdata[119:112] + 8'd64));

      s2_w <= s1_w;
      for (int j = 0; j < 3; j++) begin
        s2_ppo[j] <= $signed(s1_op[j]) * $signed({1'b0, s1_w});
        s2_ppn[j] <= $signed(s1_np[j]) * $signed(18'(WEIGHT_ONE - s1_w));
      end
      s2_ox <= s1_ocl * s1_osn;
      s2_oy <= s1_osl * s1_osn;
      s2_nx <= s1_ncl * s1_nsn;
      s2_ny <= s1_nsl * s1_nsn;
      s2_oz <= s1_ocn;
      s2_nz <= s1_ncn;

      s3_w <= s2_w;
      for (int j = 0; j < 3; j++) begin
        s3_pos[j] <= 32'(s2_ppo[j] + s2_ppn[j]);
      end
      s3_on[0] <= round_q14(s2_ox);
      s3_on[1] <= round_q14(s2_oy);
      s3_on[2] <= s2_oz;
      s3_nn[0] <= round_q14(s2_nx);
      s3_nn[1] <= round_q14(s2_ny);
      s3_nn[2] <= s2_nz;

      for (int j = 0; j < 3; j++) begin
        s4_bo[j] <= s3_on[j] * $signed({1'b0, s3_w});
        s4_bn[j] <= $signed(s3_nn[j]) * $signed(18'(WEIGHT_ONE - s3_w));
      end
      s4_pos <= s3_pos;
      s4_nn  <= s3_nn;
      s4_wz  <= (s3_w == '0);

      s5_c.pos <= s4_pos;
      s5_c.nn  <= s4_nn;
      s5_c.wz  <= s4_wz;
      for (int j = 0; j < 3; j++) begin
        logic signed [33:0] b;
        b = s4_bo[j] + s4_bn[j];
        s5_c.neg[j] <= b[33];
        s5_c.m[j]   <= b[33] ? 31'(-b) : 31'(b);
      end

      s6_c <= s5_c;
      for (int j = 0; j < 3; j++) begin
        s6_sq[j] <= s5_c.m[j] * s5_c.m[j];
      end

      s7_c   <= s6_c;
      s7_sum <= 64'(s6_sq[0]) + 64'(s6_sq[1]) + 64'(s6_sq[2]);
    end
  end

  // One root bit per stage: bring down two radicand bits, try (root << 2) | 1.
  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      logic [63:0] x;
      logic [35:0] rem, r2, trial;
      logic [31:0] root;
      x     = (k == 0) ? s7_sum : sq_x[(k == 0) ? 0 : k - 1];
      rem   = (k == 0) ? '0 : sq_rem[(k == 0) ? 0 : k - 1];
      root  = (k == 0) ? '0 : sq_root[(k == 0) ? 0 : k - 1];
      r2    = {rem[33:0], x[63:62]};
      trial = {2'b00, root, 2'b01};
      sq_x_next[k] = {x[61:0], 2'b00};
      if (r2 >= trial) begin
        sq_rem_next[k]  = r2 - trial;
        sq_root_next[k] = {root[30:0], 1'b1};
      end else begin
        sq_rem_next[k]  = r2;
        sq_root_next[k] = {root[30:0], 1'b0};
      end
    end
  end

  // Restoring division of (m * 32768 + len) by 2 * len, one quotient bit per stage.
  always_comb begin
    for (int t = 0; t < DIV_STEPS; t++) begin
      for (int j = 0; j < 3; j++) begin
        logic [47:0] r, d;
        logic [14:0] q;
        if (t == 0) begin
          r = {2'b00, sq_c[SQ_STEPS-1].m[j], 15'd0} + 48'(sq_root[SQ_STEPS-1]);
          q = '0;
        end else begin
          r = dv_r[(t == 0) ? 0 : t - 1][j];
          q = dv_q[(t == 0) ? 0 : t - 1][j];
        end
        d = 48'({((t == 0) ? sq_root[SQ_STEPS-1] : dv_len[(t == 0) ? 0 : t - 1]), 1'b0})
            << (DIV_STEPS - 1 - t);
        if (r >= d) begin
          dv_r_next[t][j] = r - d;
          dv_q_next[t][j] = q | (15'd1 << (DIV_STEPS - 1 - t));
        end else begin
          dv_r_next[t][j] = r;
          dv_q_next[t][j] = q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        sq_x[k]    <= sq_x_next[k];
        sq_rem[k]  <= sq_rem_next[k];
        sq_root[k] <= sq_root_next[k];
        sq_c[k]    <= (k == 0) ? s7_c : sq_c[(k == 0) ? 0 : k - 1];
      end
      for (int t = 0; t < DIV_STEPS; t++) begin
        dv_len[t] <= (t == 0) ? sq_root[SQ_STEPS-1] : dv_len[(t == 0) ? 0 : t - 1];
        dv_c[t]   <= (t == 0) ? sq_c[SQ_STEPS-1] : dv_c[(t == 0) ? 0 : t - 1];
        for (int j = 0; j < 3; j++) begin
          dv_r[t][j] <= dv_r_next[t][j];
          dv_q[t][j] <= dv_q_next[t][j];
        end
      end
    end
  end

  // In copy mode the decoded new normal passes unchanged; a zero blend gives a zero normal.
  always_comb begin
    logic [2:0][15:0] nrm;
    for (int j = 0; j < 3; j++) begin
      logic [14:0] qc;
      qc = (dv_q[DIV_STEPS-1][j] > NORM_ONE) ? NORM_ONE : dv_q[DIV_STEPS-1][j];
      if (dv_c[DIV_STEPS-1].wz) begin
        nrm[j] = dv_c[DIV_STEPS-1].nn[j];
      end else if (dv_len[DIV_STEPS-1] == '0) begin
        nrm[j] = '0;
      end else if (dv_c[DIV_STEPS-1].neg[j]) begin
        nrm[j] = 16'(-{1'b0, qc});
      end else begin
        nrm[j] = {1'b0, qc};
      end
    end
    res_data = {nrm, dv_c[DIV_STEPS-1].pos};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (!out_v || m_tready) begin
      if (sk_v) begin
        out_v <= 1'b1;
        sk_v  <= 1'b0;
      end else begin
        out_v <= v[NST-1];
      end
    end else if (v[NST-1] && en) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_tready) begin
      out_data <= sk_v ? sk_data : res_data;
    end else if (v[NST-1] && en) begin
      sk_data <= res_data;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_data;

  `MVLND_ASSERT_NOW(a_weight_clamped, 1'b1, weight <= WEIGHT_ONE)
  `MVLND_ASSERT_NOW(a_skid_needs_out, sk_v, out_v)
  `MVLND_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v[0])
  `MVLND_ASSERT_NOW(a_quot_bound, v[NST-1] && dv_len[DIV_STEPS-1] != '0,
    dv_q[DIV_STEPS-1][0] <= NORM_ONE)

endmodule
